>>> rtl/mi3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths and payload types of the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_WIDTH    = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int EPS_W         = 31;
	localparam int NELEM         = 9;
	// exact 2x2 minor and exact determinant widths
	localparam int MW = 2 * ELEM_WIDTH + 1;
	localparam int DW = 3 * ELEM_WIDTH + 3;
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] a00;
		logic signed [ELEM_WIDTH-1:0] a01;
		logic signed [ELEM_WIDTH-1:0] a02;
		logic signed [ELEM_WIDTH-1:0] a10;
		logic signed [ELEM_WIDTH-1:0] a11;
		logic signed [ELEM_WIDTH-1:0] a12;
		logic signed [ELEM_WIDTH-1:0] a20;
		logic signed [ELEM_WIDTH-1:0] a21;
		logic signed [ELEM_WIDTH-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic                         invertible;
		logic signed [ELEM_WIDTH-1:0] b00;
		logic signed [ELEM_WIDTH-1:0] b01;
		logic signed [ELEM_WIDTH-1:0] b02;
		logic signed [ELEM_WIDTH-1:0] b10;
		logic signed [ELEM_WIDTH-1:0] b11;
		logic signed [ELEM_WIDTH-1:0] b12;
		logic signed [ELEM_WIDTH-1:0] b20;
		logic signed [ELEM_WIDTH-1:0] b21;
		logic signed [ELEM_WIDTH-1:0] b22;
	} inv_t;

endpackage
`default_nettype wire

>>> rtl/mi3_det.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Five-stage front end: element products, signed adjugate, determinant.
// ----------------------------------------------------------------------------
module mi3_det (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  mi3_pkg::mat_t                    mat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [mi3_pkg::DW-1:0]    det,
	output logic signed [mi3_pkg::MW-1:0]    adj [mi3_pkg::NELEM]
);

	localparam int EW = mi3_pkg::ELEM_WIDTH;
	localparam int MW = mi3_pkg::MW;
	localparam int DW = mi3_pkg::DW;
	localparam int NE = mi3_pkg::NELEM;
	localparam int NS = 5;

	// adj[r*3+c] = e[PP_A]*e[PP_B] - e[PN_A]*e[PN_B], cofactor sign included
	localparam int PP_A [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int PP_B [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PN_A [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int PN_B [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	logic signed [EW-1:0]     e [NE];
	logic [NS-1:0]            vld_s;
	logic [NS-1:0]            en;

	logic signed [2*EW-1:0]   pp_s1 [NE];
	logic signed [2*EW-1:0]   pn_s1 [NE];
	logic signed [EW-1:0]     a0_s1 [3];
	logic signed [MW-1:0]     adj_s2 [NE];
	logic signed [EW-1:0]     a0_s2 [3];
	logic signed [2*EW:0]     plo_s3 [3];
	logic signed [2*EW:0]     phi_s3 [3];
	logic signed [MW-1:0]     adj_s3 [NE];
	logic signed [DW-1:0]     t_s4 [3];
	logic signed [MW-1:0]     adj_s4 [NE];
	logic signed [DW-1:0]     det_s5;
	logic signed [MW-1:0]     adj_s5 [NE];

	assign e[0] = mat.a00;
	assign e[1] = mat.a01;
	assign e[2] = mat.a02;
	assign e[3] = mat.a10;
	assign e[4] = mat.a11;
	assign e[5] = mat.a12;
	assign e[6] = mat.a20;
	assign e[7] = mat.a21;
	assign e[8] = mat.a22;

	// a stage loads when empty or when the next one moves
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NE; i++) begin
				pp_s1[i] <= e[PP_A[i]] * e[PP_B[i]];
				pn_s1[i] <= e[PN_A[i]] * e[PN_B[i]];
			end
			for (int k = 0; k < 3; k++) begin
				a0_s1[k] <= e[k];
			end
		end
		if (en[1]) begin
			for (int i = 0; i < NE; i++) begin
				adj_s2[i] <= {pp_s1[i][2*EW-1], pp_s1[i]} - {pn_s1[i][2*EW-1], pn_s1[i]};
			end
			a0_s2 <= a0_s1;
		end
		// row-0 element times cofactor, split into low and high halves
		if (en[2]) begin
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= a0_s2[k] * $signed({1'b0, adj_s2[3*k][EW-1:0]});
				phi_s3[k] <= a0_s2[k] * $signed(adj_s2[3*k][MW-1:EW]);
			end
			adj_s3 <= adj_s2;
		end
		if (en[3]) begin
			for (int k = 0; k < 3; k++) begin
				t_s4[k] <= (DW'(phi_s3[k]) <<< EW) + DW'(plo_s3[k]);
			end
			adj_s4 <= adj_s3;
		end
		if (en[4]) begin
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			adj_s5 <= adj_s4;
		end
	end

	assign out_valid = vld_s[NS-1];
	assign det       = det_s5;
	assign adj       = adj_s5;

endmodule
`default_nettype wire

>>> rtl/mi3_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div
// Singular check and nine-lane restoring divider, one quotient bit per
// stage, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module mi3_div #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [mi3_pkg::DW-1:0]    det,
	input  logic signed [mi3_pkg::MW-1:0]    adj [mi3_pkg::NELEM],
	input  logic [mi3_pkg::EPS_W-1:0]        eps,
	output logic                             out_valid,
	input  logic                             out_ready,
	output mi3_pkg::inv_t                    inv
);

	localparam int EW    = mi3_pkg::ELEM_WIDTH;
	localparam int MW    = mi3_pkg::MW;
	localparam int DW    = mi3_pkg::DW;
	localparam int NE    = mi3_pkg::NELEM;
	localparam int EPS_W = mi3_pkg::EPS_W;
	localparam int NW    = MW + 2 * FRAC_BITS;
	localparam int DS    = DW + EW;
	localparam int CW    = (NW > DS) ? NW : DS;
	localparam int TW    = (DW > EPS_W + 2 * FRAC_BITS) ? DW : EPS_W + 2 * FRAC_BITS;
	localparam int NSTEP = EW + 1;
	localparam int RS    = NSTEP + 1;
	localparam int FS    = NSTEP + 2;
	localparam int NS    = NSTEP + 3;

	logic [NS-1:0]   vld_s;
	logic [NS-1:0]   en;

	logic [DW-1:0]   dmag_c;
	logic            sing_c;
	logic [MW-1:0]   amag_c [NE];

	logic [DW-1:0]   dmag_s [NSTEP+1];
	logic            sing_s [RS+1];
	logic            neg_s  [RS+1][NE];
	logic [CW-1:0]   rem_s  [NSTEP+1][NE];
	logic [EW:0]     q_s    [NSTEP+1][NE];
	logic [CW-1:0]   rem_n  [1:NSTEP][NE];
	logic [EW:0]     q_n    [1:NSTEP][NE];
	logic [EW+1:0]   qr_s   [NE];
	logic            rnd_c  [NE];
	logic [EW-1:0]   b_c    [NE];
	mi3_pkg::inv_t   res_c;
	mi3_pkg::inv_t   out_s;

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// magnitudes; det is exact in Q.3F, epsilon scales up by 2F
	always_comb begin
		dmag_c = det[DW-1] ? DW'(-det) : DW'(det);
		sing_c = TW'(dmag_c) <= (TW'(eps) << (2 * FRAC_BITS));
		for (int i = 0; i < NE; i++) begin
			amag_c[i] = adj[i][MW-1] ? MW'(-adj[i]) : MW'(adj[i]);
		end
	end

	// step j decides quotient bit NSTEP-j; top bit set means overflow
	always_comb begin
		logic [CW-1:0] dsh;
		logic          ge;
		for (int j = 1; j <= NSTEP; j++) begin
			dsh = CW'(dmag_s[j-1]) << (NSTEP - j);
			for (int i = 0; i < NE; i++) begin
				ge          = rem_s[j-1][i] >= dsh;
				rem_n[j][i] = ge ? rem_s[j-1][i] - dsh : rem_s[j-1][i];
				q_n[j][i]   = q_s[j-1][i] | ((EW + 1)'(ge) << (NSTEP - j));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NE; i++) begin
			rnd_c[i] = {rem_s[NSTEP][i], 1'b0} >= (CW + 1)'(dmag_s[NSTEP]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dmag_s[0] <= dmag_c;
			sing_s[0] <= sing_c;
			for (int i = 0; i < NE; i++) begin
				rem_s[0][i] <= CW'(amag_c[i]) << (2 * FRAC_BITS);
				q_s[0][i]   <= '0;
				neg_s[0][i] <= adj[i][MW-1] ^ det[DW-1];
			end
		end
		for (int j = 1; j <= NSTEP; j++) begin
			if (en[j]) begin
				dmag_s[j] <= dmag_s[j-1];
				sing_s[j] <= sing_s[j-1];
				for (int i = 0; i < NE; i++) begin
					rem_s[j][i] <= rem_n[j][i];
					q_s[j][i]   <= q_n[j][i];
					neg_s[j][i] <= neg_s[j-1][i];
				end
			end
		end
		if (en[RS]) begin
			sing_s[RS] <= sing_s[NSTEP];
			for (int i = 0; i < NE; i++) begin
				qr_s[i]      <= (EW + 2)'(q_s[NSTEP][i]) + (EW + 2)'(rnd_c[i]);
				neg_s[RS][i] <= neg_s[NSTEP][i];
			end
		end
		if (en[FS]) begin
			out_s <= res_c;
		end
	end

	// saturate to the element range, apply sign, zero when singular
	always_comb begin
		logic [EW+1:0] lim;
		logic [EW+1:0] v;
		for (int i = 0; i < NE; i++) begin
			lim = ((EW + 2)'(1) << (EW - 1)) - (EW + 2)'(!neg_s[RS][i]);
			v   = (qr_s[i] > lim) ? lim : qr_s[i];
			if (sing_s[RS]) begin
				b_c[i] = '0;
			end else if (neg_s[RS][i]) begin
				b_c[i] = -v[EW-1:0];
			end else begin
				b_c[i] = v[EW-1:0];
			end
		end
		res_c.invertible = !sing_s[RS];
		res_c.b00 = b_c[0];
		res_c.b01 = b_c[1];
		res_c.b02 = b_c[2];
		res_c.b10 = b_c[3];
		res_c.b11 = b_c[4];
		res_c.b12 = b_c[5];
		res_c.b20 = b_c[6];
		res_c.b21 = b_c[7];
		res_c.b22 = b_c[8];
	end

	assign out_valid = vld_s[NS-1];
	assign inv       = out_s;

endmodule
`default_nettype wire

>>> rtl/matrix3_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse
// Fixed-point 3x3 matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// One matrix item is accepted per clock and one result item leaves per clock
// when the output side keeps up. Five stages form products, adjugate and
// determinant, then come a prep stage, ELEM_WIDTH+1 divider stages (one
// quotient bit each, nine lanes side by side), a rounding stage and the
// output register. Every stage holds its item while the next one is full,
// so back-pressure fills bubbles before it stalls the input. cfg_wdata is
// the singular threshold in Q.FRAC_BITS; write it only while the pipeline
// is empty.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mat_valid,
	output logic                         mat_ready,
	input  mi3_pkg::mat_t                mat,
	output logic                         inv_valid,
	input  logic                         inv_ready,
	output mi3_pkg::inv_t                inv,
	input  logic                         cfg_we,
	input  logic [mi3_pkg::EPS_W-1:0]    cfg_wdata
);

	logic [mi3_pkg::EPS_W-1:0]    eps_q;
	logic                         d_valid;
	logic                         d_ready;
	logic signed [mi3_pkg::DW-1:0] d_det;
	logic signed [mi3_pkg::MW-1:0] d_adj [mi3_pkg::NELEM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= mi3_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	mi3_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_ready  (mat_ready),
		.mat       (mat),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.det       (d_det),
		.adj       (d_adj)
	);

	mi3_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.det       (d_det),
		.adj       (d_adj),
		.eps       (eps_q),
		.out_valid (inv_valid),
		.out_ready (inv_ready),
		.inv       (inv)
	);

endmodule
`default_nettype wire
